/* rtl/ilist_pkg.sv */
// Shared types and constants for the indexed list block.
`default_nettype none

package ilist_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int KIND_W       = 2;
    localparam int ST_W         = 2;
    localparam int CAPACITY_DEF = 64;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic clr;
        logic upd;
    } t_mm_ctl;

endpackage

`default_nettype wire

/* rtl/ilist_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module ilist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/ilist_mmu.sv */
// Running signed max/min accumulator shared by every scan.
`default_nettype none

module ilist_mmu (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ilist_pkg::t_mm_ctl            i_ctl,
    input  wire logic [ilist_pkg::DATA_W-1:0]  i_data,
    output logic      [ilist_pkg::DATA_W-1:0]  o_max,
    output logic      [ilist_pkg::DATA_W-1:0]  o_min
);

    import ilist_pkg::*;

    logic              r_first;
    logic [DATA_W-1:0] r_max;
    logic [DATA_W-1:0] r_min;
    logic              gt_max;
    logic              lt_min;

    assign gt_max = $signed(i_data) > $signed(r_max);
    assign lt_min = $signed(i_data) < $signed(r_min);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (i_ctl.clr) begin
            r_first <= 1'b1;
        end else if (i_ctl.upd) begin
            r_first <= 1'b0;
            // first word seeds both bounds
            if (r_first || gt_max) begin
                r_max <= i_data;
            end
            if (r_first || lt_min) begin
                r_min <= i_data;
            end
        end
    end

    assign o_max = r_max;
    assign o_min = r_min;

endmodule

`default_nettype wire

/* rtl/indexed_list_insert_delete_minmax.sv */
// Indexed list with insert/delete at a position and a max/min scan per command.
// A command first shifts the affected entries, if any, then scans the whole list for max/min,
// one entry a cycle through the single RAM read port. Busy drops as o_valid rises, so the
// next start beat can land in the o_valid cycle; a new command is taken only once the last
// is through, and there is no output stall. Reset empties the list, not the RAM.
`default_nettype none

module indexed_list_insert_delete_minmax #(
    parameter int CAPACITY = ilist_pkg::CAPACITY_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ilist_pkg::KIND_W-1:0]  i_kind,
    input  wire logic [ilist_pkg::POS_W-1:0]   i_position,
    input  wire logic [ilist_pkg::DATA_W-1:0]  i_new_value,
    output logic                               o_valid,
    output logic      [ilist_pkg::ST_W-1:0]    o_status,
    output logic      [CNT_W-1:0]              o_count,
    output logic      [ilist_pkg::DATA_W-1:0]  o_largest,
    output logic      [ilist_pkg::DATA_W-1:0]  o_smallest,
    output logic                               o_is_empty
);

    import ilist_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    t_state            r_state, n_state;
    logic              r_ins, r_del;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_value;
    logic [AW-1:0]     r_ptr, r_wa;
    logic [CNT_W-1:0]  r_left, r_count, n_count;
    logic              r_pend;
    t_status           r_status;

    logic              r_o_valid, r_o_empty;
    t_status           r_o_status;
    logic [CNT_W-1:0]  r_o_count;
    logic [DATA_W-1:0] r_o_max, r_o_min;

    logic              accept;
    logic [CW-1:0]     pos_x, cnt_x;
    logic              acc_ins, acc_del;
    t_status           acc_status;
    logic [AW-1:0]     acc_ptr;
    logic [CNT_W-1:0]  acc_left;

    logic              shift_done, scan_done;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;
    t_mm_ctl           mm_ctl;
    logic [DATA_W-1:0] mm_max, mm_min;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign pos_x  = CW'(i_position);
    assign cnt_x  = CW'(r_count);

    // Command decode at the start beat
    always_comb begin
        acc_ins    = 1'b0;
        acc_del    = 1'b0;
        acc_status = ST_OK;
        acc_ptr    = '0;
        acc_left   = '0;
        case (i_kind)
            KIND_INSERT: begin
                if (pos_x == '0 || pos_x > cnt_x + CW'(1)) begin
                    acc_status = ST_RANGE;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    acc_status = ST_FULL;
                end else begin
                    acc_ins  = 1'b1;
                    acc_ptr  = AW'(cnt_x - CW'(1));
                    acc_left = CNT_W'(cnt_x - pos_x + CW'(1));
                end
            end
            KIND_DELETE: begin
                if (pos_x == '0 || pos_x > cnt_x) begin
                    acc_status = ST_RANGE;
                end else begin
                    acc_del  = 1'b1;
                    acc_ptr  = AW'(pos_x);
                    acc_left = CNT_W'(cnt_x - pos_x);
                end
            end
            default: begin
                acc_status = ST_OK;
            end
        endcase
    end

    // Datapath control
    always_comb begin
        shift_done = (r_state == S_SHIFT) && (r_left == '0) && !r_pend;
        scan_done  = (r_state == S_SCAN) && (r_left == '0) && !r_pend;
        ram_we     = 1'b0;
        ram_waddr  = r_wa;
        ram_wdata  = ram_rdata;
        if (r_state == S_SHIFT && r_pend) begin
            ram_we = 1'b1;
        end else if (shift_done && r_ins) begin
            // drop the new word into the slot opened by the shift
            ram_we    = 1'b1;
            ram_waddr = AW'(r_pos - POS_W'(1));
            ram_wdata = r_value;
        end
        mm_ctl.clr = shift_done;
        mm_ctl.upd = (r_state == S_SCAN) && r_pend;
        n_count    = r_count;
        if (shift_done && r_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (shift_done && r_del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (shift_done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_left    <= '0;
            r_pend    <= 1'b0;
            r_ins     <= 1'b0;
            r_del     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= scan_done;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ins    <= acc_ins;
                        r_del    <= acc_del;
                        r_status <= acc_status;
                        r_pos    <= i_position;
                        r_value  <= i_new_value;
                        r_ptr    <= acc_ptr;
                        r_left   <= acc_left;
                        r_pend   <= 1'b0;
                    end
                end
                S_SHIFT, S_SCAN: begin
                    r_pend <= (r_left != '0);
                    if (r_left != '0) begin
                        r_left <= r_left - CNT_W'(1);
                        // insert walks down and moves up; delete and scan walk up
                        if (r_state == S_SHIFT && r_ins) begin
                            r_ptr <= r_ptr - AW'(1);
                            r_wa  <= r_ptr + AW'(1);
                        end else begin
                            r_ptr <= r_ptr + AW'(1);
                            r_wa  <= r_ptr - AW'(1);
                        end
                    end
                    if (shift_done) begin
                        r_ptr  <= '0;
                        r_left <= n_count;
                    end
                end
                default: begin
                    r_pend <= 1'b0;
                end
            endcase
            if (scan_done) begin
                r_o_status <= r_status;
                r_o_count  <= r_count;
                r_o_empty  <= (r_count == '0);
                r_o_max    <= (r_count == '0) ? '0 : mm_max;
                r_o_min    <= (r_count == '0) ? '0 : mm_min;
            end
        end
    end

    ilist_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    ilist_mmu u_mmu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mm_ctl),
        .i_data  (ram_rdata),
        .o_max   (mm_max),
        .o_min   (mm_min)
    );

    assign o_valid    = r_o_valid;
    assign o_status   = r_o_status;
    assign o_count    = r_o_count;
    assign o_largest  = r_o_max;
    assign o_smallest = r_o_min;
    assign o_is_empty = r_o_empty;

`ifndef NO_ASSERTIONS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list length exceeds capacity");

    a_idle_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_left == '0 && !r_pend))
        else $error("walk pending while idle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy && !o_valid)
        else $error("start beat did not raise busy");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_largest == '0 && o_smallest == '0 && o_count == '0))
        else $error("empty result carries nonzero fields");
`endif

endmodule

`default_nettype wire
